@@ hdl/rfd_pkg.sv @@
// Shared types, codes and constants of the recorder frame deframer.
`default_nettype none

package rfd_pkg;

  localparam int MAX_CHANNELS_DEF = 8;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 64;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  localparam logic [31:0] TYPE_TIME = 32'd1;
  localparam logic [31:0] TYPE_AUX  = 32'd3;
  localparam logic [31:0] TYPE_TEMP = 32'd5;
  localparam logic [31:0] TYPE_END  = 32'd13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_CHANS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SKEW_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKEW_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_TIME   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SKEW_RATE   = 3'd5;

  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_TIME   = 2'd1,
    KIND_AUX    = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  typedef struct packed {
    logic [3:0]  frame_chans;
    logic [63:0] start_time_us;
    logic        skew_enable;
    logic [31:0] skew_offset_us;
    logic [63:0] sync_time_us;
    logic [47:0] skew_rate;
  } cfg_t;

  typedef struct packed {
    logic        start;
    logic        ack;
    logic [31:0] w1;
    logic [31:0] w2;
  } time_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] t;
  } time_rsp_t;

endpackage

`default_nettype wire

@@ hdl/rfd_in_if.sv @@
// Input word channel of the recorder frame deframer.
`default_nettype none

interface rfd_in_if ();
  logic              valid;
  logic              ready;
  logic signed [31:0] word;

  modport source (output valid, output word, input ready);
  modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

@@ hdl/rfd_out_if.sv @@
// Result channel of the recorder frame deframer.
`default_nettype none

interface rfd_out_if ();
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         channel;
  logic signed [31:0] sample_value;
  logic               frame_last;
  logic signed [63:0] timestamp_us;
  logic [47:0]        sample_index;
  logic signed [15:0] temperature;
  logic [15:0]        humidity;
  logic signed [15:0] battery_voltage;

  modport source (output valid, output kind, output channel, output sample_value,
                  output frame_last, output timestamp_us, output sample_index,
                  output temperature, output humidity, output battery_voltage,
                  input ready);
  modport sink (input valid, input kind, input channel, input sample_value,
                input frame_last, input timestamp_us, input sample_index,
                input temperature, input humidity, input battery_voltage,
                output ready);
endinterface

`default_nettype wire

@@ hdl/rfd_cfg_if.sv @@
// Configuration write channel of the recorder frame deframer.
`default_nettype none

interface rfd_cfg_if import rfd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ hdl/rfd_cfg_regs.sv @@
// Configuration register file of the recorder frame deframer.
`default_nettype none

module rfd_cfg_regs import rfd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  rfd_cfg_if.sink   cfg_if,
  output cfg_t      cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_FRAME_CHANS: cfg_nxt.frame_chans    = cfg_if.data[3:0];
        CFG_START_TIME:  cfg_nxt.start_time_us  = cfg_if.data;
        CFG_SKEW_ENABLE: cfg_nxt.skew_enable    = cfg_if.data[0];
        CFG_SKEW_OFFSET: cfg_nxt.skew_offset_us = cfg_if.data[31:0];
        CFG_SYNC_TIME:   cfg_nxt.sync_time_us   = cfg_if.data;
        CFG_SKEW_RATE:   cfg_nxt.skew_rate      = cfg_if.data[47:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r             <= '0;
      cfg_r.frame_chans <= 4'd1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rfd_time_unit.sv @@
// Timestamp sequencer around one shared 33x25 multiplier, with 64-bit sums and a 112-bit accumulator.
`default_nettype none

module rfd_time_unit import rfd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  cfg_t      cfg,
  input  time_req_t req,
  output time_rsp_t rsp
);

  typedef enum logic [3:0] {
    T_IDLE, T_MUL, T_SUM, T_START, T_DIFF, T_ABS, T_PP, T_NEG, T_OFS, T_SKEW, T_DONE
  } tstate_t;

  tstate_t             state_r, state_nxt;
  logic [63:0]         t_r, t_nxt;
  logic [63:0]         d_r, d_nxt;
  logic [47:0]         rmag_r, rmag_nxt;
  logic [111:0]        acc_r, acc_nxt;
  logic                neg_r, neg_nxt;
  logic [2:0]          pp_cnt_r, pp_cnt_nxt;
  logic signed [32:0]  mul_a;
  logic signed [24:0]  mul_b;
  logic signed [57:0]  prod_r;
  logic [1:0]          pp_prev;
  logic [6:0]          pp_shift;
  logic [111:0]        pp_ext;
  logic [63:0]         q;

  assign rsp.done = (state_r == T_DONE);
  assign rsp.t    = t_r;
  assign pp_prev  = 2'(pp_cnt_r - 3'd1);
  assign pp_ext   = {56'd0, prod_r[55:0]};
  assign q        = acc_r[111:48];

  always_comb begin
    case (pp_prev)
      2'd0:    pp_shift = 7'd0;
      2'd1:    pp_shift = 7'd24;
      2'd2:    pp_shift = 7'd32;
      default: pp_shift = 7'd56;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state_r == T_MUL) begin
      mul_a = $signed({req.w1[31], req.w1});
      mul_b = $signed({5'd0, US_PER_S});
    end else if (state_r == T_PP) begin
      mul_a = $signed({1'b0, (pp_cnt_r[1] ? d_r[63:32] : d_r[31:0])});
      mul_b = $signed({1'b0, (pp_cnt_r[0] ? rmag_r[47:24] : rmag_r[23:0])});
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_comb begin
    state_nxt  = state_r;
    t_nxt      = t_r;
    d_nxt      = d_r;
    rmag_nxt   = rmag_r;
    acc_nxt    = acc_r;
    neg_nxt    = neg_r;
    pp_cnt_nxt = pp_cnt_r;
    unique case (state_r)
      T_IDLE: begin
        if (req.start) state_nxt = T_MUL;
      end
      T_MUL: state_nxt = T_SUM;
      T_SUM: begin
        t_nxt     = {{6{prod_r[57]}}, prod_r} + {{32{req.w2[31]}}, req.w2};
        state_nxt = T_START;
      end
      T_START: begin
        t_nxt     = t_r + cfg.start_time_us;
        state_nxt = cfg.skew_enable ? T_DIFF : T_DONE;
      end
      T_DIFF: begin
        d_nxt     = t_r - cfg.sync_time_us;
        state_nxt = T_ABS;
      end
      T_ABS: begin
        d_nxt      = d_r[63] ? (64'd0 - d_r) : d_r;
        rmag_nxt   = cfg.skew_rate[47] ? (48'd0 - cfg.skew_rate) : cfg.skew_rate;
        neg_nxt    = d_r[63] ^ cfg.skew_rate[47];
        acc_nxt    = 112'd1 << 47;
        pp_cnt_nxt = 3'd0;
        state_nxt  = T_PP;
      end
      T_PP: begin
        if (pp_cnt_r != 3'd0) acc_nxt = acc_r + (pp_ext << pp_shift);
        pp_cnt_nxt = pp_cnt_r + 3'd1;
        if (pp_cnt_r == 3'd4) state_nxt = T_NEG;
      end
      T_NEG: begin
        d_nxt     = neg_r ? (64'd0 - q) : q;
        state_nxt = T_OFS;
      end
      T_OFS: begin
        t_nxt     = t_r + {{32{cfg.skew_offset_us[31]}}, cfg.skew_offset_us};
        state_nxt = T_SKEW;
      end
      T_SKEW: begin
        t_nxt     = t_r + d_r;
        state_nxt = T_DONE;
      end
      T_DONE: begin
        if (req.ack) state_nxt = T_IDLE;
      end
      default: state_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= T_IDLE;
      t_r      <= '0;
      d_r      <= '0;
      rmag_r   <= '0;
      acc_r    <= '0;
      neg_r    <= 1'b0;
      pp_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      t_r      <= t_nxt;
      d_r      <= d_nxt;
      rmag_r   <= rmag_nxt;
      acc_r    <= acc_nxt;
      neg_r    <= neg_nxt;
      pp_cnt_r <= pp_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rfd_frame_ctrl.sv @@
// Frame parser, stored status values and result register of the recorder frame deframer.
`default_nettype none

module rfd_frame_ctrl import rfd_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  cfg_t       cfg,
  rfd_in_if.sink     in_if,
  rfd_out_if.source  out_if,
  output time_req_t  treq,
  input  time_rsp_t  trsp
);

  typedef enum logic {S_IDLE, S_TIME} state_t;

  localparam logic [4:0] MAX_LEN = 5'(MAX_CHANNELS);

  state_t      state_r, state_nxt;
  logic [3:0]  wl_r, wl_nxt;
  logic [3:0]  wp_r, wp_nxt;
  logic        ctrl_r, ctrl_nxt;
  logic        time_seen_r, time_seen_nxt;
  logic [47:0] frame_count_r, frame_count_nxt;
  logic [63:0] last_ts_r, last_ts_nxt;
  logic [15:0] hum_r, hum_nxt;
  logic [15:0] bat_r, bat_nxt;
  logic        ended_r, ended_nxt;

  logic        ov_r, ov_nxt;
  kind_t       ok_r, ok_nxt;
  logic [2:0]  och_r, och_nxt;
  logic [31:0] osv_r, osv_nxt;
  logic        olast_r, olast_nxt;
  logic [63:0] ots_r, ots_nxt;
  logic [47:0] oidx_r, oidx_nxt;
  logic [15:0] otemp_r, otemp_nxt;
  logic [15:0] ohum_r, ohum_nxt;
  logic [15:0] obat_r, obat_nxt;

  logic [31:0] cw_r [0:2];
  logic        cw_we;
  logic [1:0]  cw_idx;

  logic        accept;
  logic        out_free;
  logic        ctrl;
  logic [3:0]  pos;
  logic [4:0]  flen;
  logic [4:0]  cc_ext;

  assign out_free    = !ov_r || out_if.ready;
  assign in_if.ready = (state_r == S_IDLE) && out_free;
  assign accept      = in_if.valid && in_if.ready;
  assign cc_ext      = {1'b0, cfg.frame_chans};
  assign flen        = (cc_ext == 5'd0) ? 5'd1 : ((cc_ext > MAX_LEN) ? MAX_LEN : cc_ext);

  assign out_if.valid           = ov_r;
  assign out_if.kind            = ok_r;
  assign out_if.channel         = och_r;
  assign out_if.sample_value    = osv_r;
  assign out_if.frame_last      = olast_r;
  assign out_if.timestamp_us    = ots_r;
  assign out_if.sample_index    = oidx_r;
  assign out_if.temperature     = otemp_r;
  assign out_if.humidity        = ohum_r;
  assign out_if.battery_voltage = obat_r;

  always_comb begin
    state_nxt       = state_r;
    wl_nxt          = wl_r;
    wp_nxt          = wp_r;
    ctrl_nxt        = ctrl_r;
    time_seen_nxt   = time_seen_r;
    frame_count_nxt = frame_count_r;
    last_ts_nxt     = last_ts_r;
    hum_nxt         = hum_r;
    bat_nxt         = bat_r;
    ended_nxt       = ended_r;
    ov_nxt          = ov_r && !out_if.ready;
    ok_nxt          = ok_r;
    och_nxt         = och_r;
    osv_nxt         = osv_r;
    olast_nxt       = olast_r;
    ots_nxt         = ots_r;
    oidx_nxt        = oidx_r;
    otemp_nxt       = otemp_r;
    ohum_nxt        = ohum_r;
    obat_nxt        = obat_r;
    treq.start      = 1'b0;
    treq.ack        = 1'b0;
    treq.w1         = cw_r[1];
    treq.w2         = cw_r[2];
    cw_we           = 1'b0;
    cw_idx          = 2'd0;
    ctrl            = ctrl_r;
    pos             = wp_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept && !ended_r) begin
          if (wl_r == 4'd0) begin
            ctrl   = in_if.word[0];
            wl_nxt = ctrl ? 4'd3 : 4'(flen - 5'd1);
            pos    = 4'd0;
            wp_nxt = 4'd1;
          end else begin
            wp_nxt = wp_r + 4'd1;
            wl_nxt = wl_r - 4'd1;
          end
          ctrl_nxt = ctrl;

          if (ctrl) begin
            cw_we  = (pos < 4'd3);
            cw_idx = pos[1:0];
            if (wl_nxt == 4'd0) begin
              unique case (cw_r[0])
                TYPE_TIME: begin
                  treq.start = 1'b1;
                  state_nxt  = S_TIME;
                end
                TYPE_AUX: begin
                  bat_nxt = cw_r[1][31:16];
                  hum_nxt = cw_r[1][15:0];
                end
                TYPE_TEMP: begin
                  ov_nxt    = 1'b1;
                  ok_nxt    = KIND_AUX;
                  och_nxt   = '0;
                  osv_nxt   = '0;
                  olast_nxt = 1'b0;
                  ots_nxt   = last_ts_r;
                  oidx_nxt  = '0;
                  otemp_nxt = cw_r[1][31:16];
                  ohum_nxt  = hum_r;
                  obat_nxt  = bat_r;
                end
                TYPE_END: begin
                  ended_nxt = 1'b1;
                  ov_nxt    = 1'b1;
                  ok_nxt    = KIND_END;
                  och_nxt   = '0;
                  osv_nxt   = '0;
                  olast_nxt = 1'b0;
                  ots_nxt   = '0;
                  oidx_nxt  = '0;
                  otemp_nxt = '0;
                  ohum_nxt  = '0;
                  obat_nxt  = '0;
                end
                default: ;
              endcase
            end
          end else if (time_seen_r) begin
            ov_nxt    = 1'b1;
            ok_nxt    = KIND_SAMPLE;
            och_nxt   = pos[2:0];
            osv_nxt   = in_if.word;
            olast_nxt = (wl_nxt == 4'd0);
            ots_nxt   = '0;
            oidx_nxt  = '0;
            otemp_nxt = '0;
            ohum_nxt  = '0;
            obat_nxt  = '0;
            if (wl_nxt == 4'd0) frame_count_nxt = frame_count_r + 48'd1;
          end
        end
      end
      S_TIME: begin
        if (trsp.done && out_free) begin
          treq.ack      = 1'b1;
          last_ts_nxt   = trsp.t;
          time_seen_nxt = 1'b1;
          ov_nxt        = 1'b1;
          ok_nxt        = KIND_TIME;
          och_nxt       = '0;
          osv_nxt       = '0;
          olast_nxt     = 1'b0;
          ots_nxt       = trsp.t;
          oidx_nxt      = frame_count_r;
          otemp_nxt     = '0;
          ohum_nxt      = '0;
          obat_nxt      = '0;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cw_we) cw_r[cw_idx] <= in_if.word;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      wl_r          <= '0;
      wp_r          <= '0;
      ctrl_r        <= 1'b0;
      time_seen_r   <= 1'b0;
      frame_count_r <= '0;
      last_ts_r     <= '0;
      hum_r         <= '0;
      bat_r         <= '0;
      ended_r       <= 1'b0;
      ov_r          <= 1'b0;
      ok_r          <= KIND_SAMPLE;
      och_r         <= '0;
      osv_r         <= '0;
      olast_r       <= 1'b0;
      ots_r         <= '0;
      oidx_r        <= '0;
      otemp_r       <= '0;
      ohum_r        <= '0;
      obat_r        <= '0;
    end else begin
      state_r       <= state_nxt;
      wl_r          <= wl_nxt;
      wp_r          <= wp_nxt;
      ctrl_r        <= ctrl_nxt;
      time_seen_r   <= time_seen_nxt;
      frame_count_r <= frame_count_nxt;
      last_ts_r     <= last_ts_nxt;
      hum_r         <= hum_nxt;
      bat_r         <= bat_nxt;
      ended_r       <= ended_nxt;
      ov_r          <= ov_nxt;
      ok_r          <= ok_nxt;
      och_r         <= och_nxt;
      osv_r         <= osv_nxt;
      olast_r       <= olast_nxt;
      ots_r         <= ots_nxt;
      oidx_r        <= oidx_nxt;
      otemp_r       <= otemp_nxt;
      ohum_r        <= ohum_nxt;
      obat_r        <= obat_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/recorder_frame_deframer.sv @@
// Top level of the recorder frame deframer.
//
//   Channel   Direction  Beat contents
//   in_if     sink       word: one 32-bit recorder stream word
//   out_if    source     kind, channel, sample value, frame last, timestamp,
//                        sample index, temperature, humidity, battery voltage
//   cfg_if    sink       index and data of one configuration register write
//
// A new word is taken only while the output register is free, and not after the
// last word of a time frame until the timestamp sequencer has run its sums and,
// with skew correction, its four partial products through the shared multiplier.
// Reset is synchronous and active low; the first word is accepted on the
// cycle after reset is released.
// A result waits in an output register; in_if.ready stays high while that
// register is empty or being taken and no timestamp is being computed.
`default_nettype none

module recorder_frame_deframer import rfd_pkg::*; #(
  parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
  input wire logic  clk,
  input wire logic  rst_n,
  rfd_in_if.sink    in_if,
  rfd_out_if.source out_if,
  rfd_cfg_if.sink   cfg_if
);

  cfg_t      cfg;
  time_req_t treq;
  time_rsp_t trsp;

  rfd_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  rfd_time_unit u_time_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .req   (treq),
    .rsp   (trsp)
  );

  rfd_frame_ctrl #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_frame_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .in_if  (in_if),
    .out_if (out_if),
    .treq   (treq),
    .trsp   (trsp)
  );

endmodule

`default_nettype wire
